@@ rtl/tdq_pkg.sv @@
// Shared types, codes and constants of the timer deadline queue.
package tdq_pkg;

  localparam int NumTimersDef = 16;
  localparam int TickBitsDef  = 48;

  // Fixed field widths of the command and result words.
  localparam int CmdW   = 2;
  localparam int IdxW   = 4;
  localparam int TickW  = 48;

  // A run reports at most this many expiries before its closing marker.
  localparam int MaxExpiries = 16;
  localparam int ExpCntW     = $clog2(MaxExpiries + 1);

  typedef enum logic [CmdW-1:0] {
    CMD_ARM    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_RUN    = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    EV_ACK     = 2'd0,
    EV_EXPIRED = 2'd1,
    EV_REPORT  = 2'd2
  } event_kind_e;

  typedef struct packed {
    logic accept;
    logic scan_init;
    logic scan_step;
    logic emit_ack;
    logic emit_report;
    logic emit_expire;
    logic emit_marker;
  } tdq_ctrl_t;

  typedef struct packed {
    logic scan_done;
    logic due;
    logic is_query;
  } tdq_stat_t;

endpackage

@@ rtl/tdq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tdq_ram #(
  parameter int Width = 48,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/tdq_ctrl.sv @@
// Controller state machine that sequences commands, scans and result words.
module tdq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic [1:0]          cmd_i,
  input  tdq_pkg::tdq_stat_t  stat_i,
  output tdq_pkg::tdq_ctrl_t  ctrl_o,
  output logic                busy
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ACK    = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_DECIDE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  tdq_pkg::cmd_e cmd_in;

  assign cmd_in = tdq_pkg::cmd_e'(cmd_i);

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          ctrl_o.accept = 1'b1;
          if (cmd_in inside {tdq_pkg::CMD_ARM, tdq_pkg::CMD_CANCEL}) begin
            state_d = ST_ACK;
          end else begin
            ctrl_o.scan_init = 1'b1;
            state_d          = ST_SCAN;
          end
        end
      end
      ST_ACK: begin
        ctrl_o.emit_ack = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_SCAN: begin
        ctrl_o.scan_step = 1'b1;
        if (stat_i.scan_done) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat_i.is_query) begin
          ctrl_o.emit_report = 1'b1;
          state_d            = ST_IDLE;
        end else if (stat_i.due) begin
          // Expire the earliest timer and look again for the next one.
          ctrl_o.emit_expire = 1'b1;
          ctrl_o.scan_init   = 1'b1;
          state_d            = ST_SCAN;
        end else begin
          ctrl_o.emit_marker = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

@@ rtl/tdq_datapath.sv @@
// Datapath: pending flags, deadline RAM, minimum scan and result word registers.
module tdq_datapath #(
  parameter int NumTimers = tdq_pkg::NumTimersDef,
  parameter int TickBits  = tdq_pkg::TickBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tdq_pkg::tdq_ctrl_t        ctrl_i,
  output tdq_pkg::tdq_stat_t        stat_o,
  input  logic [tdq_pkg::CmdW-1:0]  cmd_i,
  input  logic [tdq_pkg::IdxW-1:0]  timer_index_i,
  input  logic [tdq_pkg::TickW-1:0] tick_value_i,
  output logic                      result_valid_o,
  output logic [1:0]                event_kind_o,
  output logic [tdq_pkg::IdxW-1:0]  expired_index_o,
  output logic [tdq_pkg::TickW-1:0] deadline_out_o,
  output logic                      queue_empty_o,
  output logic                      last_result_o
);

  localparam int AddrW = $clog2(NumTimers);
  localparam int CntW  = $clog2(NumTimers + 1);
  localparam int DlW   = (TickBits < tdq_pkg::TickW) ? TickBits : tdq_pkg::TickW;

  logic [NumTimers-1:0]            pending_q;
  logic [NumTimers-1:0]            pending_after;
  tdq_pkg::cmd_e                   cmd_q;
  logic [DlW-1:0]                  tick_q;
  logic [tdq_pkg::ExpCntW-1:0]     n_q;
  logic [CntW-1:0]                 cnt_q;
  logic                            cmp_valid_q;
  logic [AddrW-1:0]                cmp_idx_q;
  logic                            found_q;
  logic [AddrW-1:0]                best_idx_q;
  logic [DlW-1:0]                  best_dl_q;
  logic [DlW-1:0]                  rd_data;
  logic                            in_range;
  logic [AddrW-1:0]                wr_addr;
  logic                            ram_we;
  logic                            scan_done;
  logic                            take;
  logic                            valid_q;
  tdq_pkg::event_kind_e            ev_q;
  logic [tdq_pkg::IdxW-1:0]        idx_q;
  logic [tdq_pkg::TickW-1:0]       dl_q;
  logic                            empty_q;
  logic                            last_q;

  assign in_range = (32'(timer_index_i) < NumTimers);
  assign wr_addr  = AddrW'(timer_index_i);
  assign ram_we   = ctrl_i.accept && in_range && (tdq_pkg::cmd_e'(cmd_i) == tdq_pkg::CMD_ARM);

  tdq_ram #(
    .Width (DlW),
    .Depth (NumTimers)
  ) u_deadlines (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (tick_value_i[DlW-1:0]),
    .raddr_i (cnt_q[AddrW-1:0]),
    .rdata_o (rd_data)
  );

  assign scan_done = (cnt_q == CntW'(NumTimers));
  // Strict less-than keeps the lower index on equal deadlines.
  assign take = cmp_valid_q && pending_q[cmp_idx_q] &&
                (!found_q || (rd_data < best_dl_q));

  always_comb begin
    pending_after             = pending_q;
    pending_after[best_idx_q] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (ctrl_i.accept && in_range) begin
      if (tdq_pkg::cmd_e'(cmd_i) == tdq_pkg::CMD_ARM) begin
        pending_q[wr_addr] <= 1'b1;
      end else if (tdq_pkg::cmd_e'(cmd_i) == tdq_pkg::CMD_CANCEL) begin
        pending_q[wr_addr] <= 1'b0;
      end
    end else if (ctrl_i.emit_expire) begin
      pending_q <= pending_after;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cmp_valid_q <= 1'b0;
      found_q     <= 1'b0;
      n_q         <= '0;
    end else begin
      if (ctrl_i.scan_init) begin
        cnt_q       <= '0;
        cmp_valid_q <= 1'b0;
        found_q     <= 1'b0;
      end else if (ctrl_i.scan_step) begin
        if (!scan_done) begin
          cnt_q <= cnt_q + CntW'(1);
        end
        cmp_valid_q <= !scan_done;
        if (take) begin
          found_q <= 1'b1;
        end
      end
      if (ctrl_i.accept) begin
        n_q <= '0;
      end else if (ctrl_i.emit_expire) begin
        n_q <= n_q + tdq_pkg::ExpCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      cmd_q  <= tdq_pkg::cmd_e'(cmd_i);
      tick_q <= tick_value_i[DlW-1:0];
    end
    cmp_idx_q <= cnt_q[AddrW-1:0];
    if (ctrl_i.scan_step && take) begin
      best_idx_q <= cmp_idx_q;
      best_dl_q  <= rd_data;
    end
  end

  assign stat_o.scan_done = scan_done;
  assign stat_o.is_query  = (cmd_q == tdq_pkg::CMD_QUERY);
  assign stat_o.due       = found_q && (best_dl_q <= tick_q) &&
                            (n_q < tdq_pkg::ExpCntW'(tdq_pkg::MaxExpiries));

  // Result word registers; the strobe is the only one that needs a reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl_i.emit_ack || ctrl_i.emit_report ||
                 ctrl_i.emit_expire || ctrl_i.emit_marker;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit_ack || ctrl_i.emit_marker) begin
      ev_q    <= tdq_pkg::EV_ACK;
      idx_q   <= '0;
      dl_q    <= '0;
      empty_q <= ~|pending_q;
      last_q  <= 1'b1;
    end else if (ctrl_i.emit_report) begin
      ev_q    <= tdq_pkg::EV_REPORT;
      idx_q   <= found_q ? tdq_pkg::IdxW'(best_idx_q) : '0;
      dl_q    <= found_q ? tdq_pkg::TickW'(best_dl_q) : '0;
      empty_q <= !found_q;
      last_q  <= 1'b1;
    end else if (ctrl_i.emit_expire) begin
      ev_q    <= tdq_pkg::EV_EXPIRED;
      idx_q   <= tdq_pkg::IdxW'(best_idx_q);
      dl_q    <= tdq_pkg::TickW'(best_dl_q);
      empty_q <= ~|pending_after;
      last_q  <= 1'b0;
    end
  end

  assign result_valid_o  = valid_q;
  assign event_kind_o    = ev_q;
  assign expired_index_o = idx_q;
  assign deadline_out_o  = dl_q;
  assign queue_empty_o   = empty_q;
  assign last_result_o   = last_q;

endmodule

@@ rtl/timer_deadline_queue_top.sv @@
// Top level of the timer deadline queue: controller, datapath and checks.
// Arm and cancel: a single result word, emitted from the ACK state and registered.
// Query: one scan of the deadline RAM, then a single report word.
// Run with k expiries: one scan per word, each expiry word followed by a new scan,
// then a closing marker once no timer is due.
// Reset clears every pending flag; deadlines hold garbage until armed; no stall.
module timer_deadline_queue_top #(
  parameter int NumTimers = tdq_pkg::NumTimersDef,
  parameter int TickBits  = tdq_pkg::TickBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [tdq_pkg::CmdW-1:0]  cmd_i,
  input  logic [tdq_pkg::IdxW-1:0]  timer_index_i,
  input  logic [tdq_pkg::TickW-1:0] tick_value_i,
  output logic                      result_valid_o,
  output logic [1:0]                event_kind_o,
  output logic [tdq_pkg::IdxW-1:0]  expired_index_o,
  output logic [tdq_pkg::TickW-1:0] deadline_out_o,
  output logic                      queue_empty_o,
  output logic                      last_result_o
);

  tdq_pkg::tdq_ctrl_t ctrl;
  tdq_pkg::tdq_stat_t stat;

  tdq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy   (busy)
  );

  tdq_datapath #(
    .NumTimers (NumTimers),
    .TickBits  (TickBits)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .cmd_i           (cmd_i),
    .timer_index_i   (timer_index_i),
    .tick_value_i    (tick_value_i),
    .result_valid_o  (result_valid_o),
    .event_kind_o    (event_kind_o),
    .expired_index_o (expired_index_o),
    .deadline_out_o  (deadline_out_o),
    .queue_empty_o   (queue_empty_o),
    .last_result_o   (last_result_o)
  );

  // Result words never come in back-to-back cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for two cycles");

  // An accepted command keeps the block busy and produces no word the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !result_valid_o))
    else $error("accepted command did not occupy the block");

  // Only expiry words are not final.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_result_o) |-> (event_kind_o == tdq_pkg::EV_EXPIRED))
    else $error("non-final word that is not an expiry");

  // An expiry never reports a deadline past the tick the run was started with.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (event_kind_o == tdq_pkg::EV_EXPIRED)) |-> $past(stat.due, 1))
    else $error("expiry word without a due timer");

endmodule
